// ===== hw/rtl/v0im_pkg.sv =====
// ----------------------------------------------------------------------------
// v0im_pkg
// Shared constants and types of the pair invariant mass classifier.
// ----------------------------------------------------------------------------
package v0im_pkg;

    localparam int MASS_BITS = 20;
    localparam int FLOOR_BITS = 32;
    localparam int OUT_BITS = 33;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [OUT_BITS-1:0] OUT_MAX = 33'h1_FFFF_FFFF;

    localparam int E_MINUS = 11;
    localparam int PI_PLUS = 211;
    localparam int PI_NEG = -211;
    localparam int PROTON = 2212;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK = 2'd0;
    localparam t_status ST_NO_MATCH = 2'd1;
    localparam t_status ST_LOW_MASS = 2'd2;

    typedef logic [1:0] t_class;
    localparam t_class PHOTON = 2'd0;
    localparam t_class K_SHORT = 2'd1;
    localparam t_class LAMBDA = 2'd2;
    localparam t_class ANTI_LAMBDA = 2'd3;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_ELECTRON_MASS = 2'd0;
    localparam t_cfg_idx REG_PION_MASS = 2'd1;
    localparam t_cfg_idx REG_PROTON_MASS = 2'd2;
    localparam t_cfg_idx REG_MIN_MASS_SQ = 2'd3;

    localparam logic [MASS_BITS-1:0] RST_ELECTRON_MASS = 20'd511;
    localparam logic [MASS_BITS-1:0] RST_PION_MASS = 20'd139570;
    localparam logic [MASS_BITS-1:0] RST_PROTON_MASS = 20'd938272;
    localparam logic [FLOOR_BITS-1:0] RST_MIN_MASS_SQ = 32'd1;

    localparam int OUT_WORD_BITS = 2 + 2 + OUT_BITS + OUT_BITS;

endpackage

// ===== hw/rtl/v0im_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// v0im_sqrt_cell
// One digit step of a pipelined integer square root with a passed-along payload.
// ----------------------------------------------------------------------------
module v0im_sqrt_cell #(
    parameter int W = 66,
    parameter int PW = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [W-1:0]     i_rad,
    input  logic [W/2+1:0]   i_rem,
    input  logic [W/2-1:0]   i_root,
    input  logic [PW-1:0]    i_pay,
    output logic [W-1:0]     o_rad,
    output logic [W/2+1:0]   o_rem,
    output logic [W/2-1:0]   o_root,
    output logic [PW-1:0]    o_pay
);
    localparam int QW = W / 2;
    localparam int RW = QW + 2;

    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;
    logic [W-1:0]  r_rad;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_root;
    logic [PW-1:0] r_pay;
    logic [W-1:0]  n_rad;
    logic [RW-1:0] n_rem;
    logic [QW-1:0] n_root;

    always_comb begin
        rem_sh = {i_rem[RW-3:0], i_rad[W-1:W-2]};
        trial = {i_root, 2'b01};
        ge = (rem_sh >= trial);
        n_rem = ge ? (rem_sh - trial) : rem_sh;
        n_root = {i_root[QW-2:0], ge};
        n_rad = {i_rad[W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad <= n_rad;
            r_rem <= n_rem;
            r_root <= n_root;
            r_pay <= i_pay;
        end
    end

    assign o_rad = r_rad;
    assign o_rem = r_rem;
    assign o_root = r_root;
    assign o_pay = r_pay;

endmodule

// ===== hw/rtl/v0im_prep.sv =====
// ----------------------------------------------------------------------------
// v0im_prep
// Species matching, momentum magnitudes, squares and squared norms in three stages.
// ----------------------------------------------------------------------------
module v0im_prep #(
    parameter int MB = 32,
    parameter int SB = 13
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [MB-1:0]                    i_p1_x,
    input  logic [MB-1:0]                    i_p1_y,
    input  logic [MB-1:0]                    i_p1_z,
    input  logic [MB-1:0]                    i_p2_x,
    input  logic [MB-1:0]                    i_p2_y,
    input  logic [MB-1:0]                    i_p2_z,
    input  logic [SB-1:0]                    i_species_1,
    input  logic [SB-1:0]                    i_species_2,
    input  logic [v0im_pkg::MASS_BITS-1:0]   i_electron_mass,
    input  logic [v0im_pkg::MASS_BITS-1:0]   i_pion_mass,
    input  logic [v0im_pkg::MASS_BITS-1:0]   i_proton_mass,
    output logic                             o_valid,
    output logic [2*((MB > 20) ? MB : 21)+1:0] o_n1,
    output logic [2*((MB > 20) ? MB : 21)+1:0] o_n2,
    output logic [2*MB+1:0]                  o_ptot2,
    output logic [1:0]                       o_status,
    output logic [1:0]                       o_class
);
    import v0im_pkg::*;

    localparam int MR = (MB > 20) ? MB : 21;
    localparam int NW = 2 * MR + 2;
    localparam int PTW = 2 * MB + 2;
    localparam int QW = 2 * MB;
    localparam int MQ = 2 * MASS_BITS;

    logic [SB:0]          s1x, s2x, a1, a2;
    logic [MB-1:0]        mag [0:5];
    logic [MB-1:0]        comp [0:5];
    logic [MB:0]          sm [0:2];
    logic [MB:0]          smag [0:2];
    t_status              st0;
    t_class               cl0;
    logic [MASS_BITS-1:0] m1, m2;

    logic                 r0_v;
    logic [MB-1:0]        r0_a [0:5];
    logic [MB:0]          r0_s [0:2];
    logic [MASS_BITS-1:0] r0_m1, r0_m2;
    t_status              r0_st;
    t_class               r0_cl;

    logic                 r1_v;
    logic [QW-1:0]        r1_q [0:5];
    logic [PTW-1:0]       r1_qs [0:2];
    logic [MQ-1:0]        r1_mm1, r1_mm2;
    t_status              r1_st;
    t_class               r1_cl;

    logic                 r2_v;
    logic [NW-1:0]        r2_n1, r2_n2;
    logic [PTW-1:0]       r2_pt;
    t_status              r2_st;
    t_class               r2_cl;

    always_comb begin
        comp[0] = i_p1_x;
        comp[1] = i_p1_y;
        comp[2] = i_p1_z;
        comp[3] = i_p2_x;
        comp[4] = i_p2_y;
        comp[5] = i_p2_z;
        for (int k = 0; k < 6; k++) begin
            mag[k] = comp[k][MB-1] ? (~comp[k] + 1'b1) : comp[k];
        end
        for (int k = 0; k < 3; k++) begin
            sm[k] = {comp[k][MB-1], comp[k]} + {comp[k+3][MB-1], comp[k+3]};
            smag[k] = sm[k][MB] ? (~sm[k] + 1'b1) : sm[k];
        end
        s1x = {i_species_1[SB-1], i_species_1};
        s2x = {i_species_2[SB-1], i_species_2};
        a1 = s1x[SB] ? (~s1x + 1'b1) : s1x;
        a2 = s2x[SB] ? (~s2x + 1'b1) : s2x;
        st0 = ST_OK;
        cl0 = PHOTON;
        m1 = '0;
        m2 = '0;
        priority if (a1 == (SB+1)'(E_MINUS) && a2 == (SB+1)'(E_MINUS)) begin
            m1 = i_electron_mass;
            m2 = i_electron_mass;
        end else if (a1 == (SB+1)'(PI_PLUS) && a2 == (SB+1)'(PI_PLUS)) begin
            m1 = i_pion_mass;
            m2 = i_pion_mass;
            cl0 = K_SHORT;
        end else if (a1 == (SB+1)'(PROTON) && a2 == (SB+1)'(PI_PLUS)) begin
            m1 = i_proton_mass;
            m2 = i_pion_mass;
            cl0 = (i_species_1 == SB'(PROTON)) ? LAMBDA : ANTI_LAMBDA;
        end else if (a1 == (SB+1)'(PI_PLUS) && a2 == (SB+1)'(PROTON)) begin
            m1 = i_pion_mass;
            m2 = i_proton_mass;
            cl0 = (i_species_2 == SB'(PROTON)) ? LAMBDA : ANTI_LAMBDA;
        end else begin
            st0 = ST_NO_MATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_en) begin
            r0_v <= i_valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_a <= mag;
            r0_s <= smag;
            r0_m1 <= m1;
            r0_m2 <= m2;
            r0_st <= st0;
            r0_cl <= cl0;
            for (int k = 0; k < 6; k++) begin
                r1_q[k] <= QW'(r0_a[k]) * QW'(r0_a[k]);
            end
            for (int k = 0; k < 3; k++) begin
                r1_qs[k] <= PTW'(r0_s[k]) * PTW'(r0_s[k]);
            end
            r1_mm1 <= MQ'(r0_m1) * MQ'(r0_m1);
            r1_mm2 <= MQ'(r0_m2) * MQ'(r0_m2);
            r1_st <= r0_st;
            r1_cl <= r0_cl;
            r2_n1 <= NW'(r1_q[0]) + NW'(r1_q[1]) + NW'(r1_q[2]) + NW'(r1_mm1);
            r2_n2 <= NW'(r1_q[3]) + NW'(r1_q[4]) + NW'(r1_q[5]) + NW'(r1_mm2);
            r2_pt <= r1_qs[0] + r1_qs[1] + r1_qs[2];
            r2_st <= r1_st;
            r2_cl <= r1_cl;
        end
    end

    assign o_valid = r2_v;
    assign o_n1 = r2_n1;
    assign o_n2 = r2_n2;
    assign o_ptot2 = r2_pt;
    assign o_status = r2_st;
    assign o_class = r2_cl;

endmodule

// ===== hw/rtl/v0_pair_invariant_mass_classifier_core.sv =====
// ----------------------------------------------------------------------------
// v0_pair_invariant_mass_classifier_core
// Classifies a track pair by species and computes its summed energy and mass.
// ----------------------------------------------------------------------------
// The pipeline has three front stages, one root cell per energy bit, three mass
// stages, one root cell per mass bit and the output register. It accepts one
// transaction per cycle while o_stall is low.
// A synchronous active-low reset empties the pipeline and restores the registers.
module v0_pair_invariant_mass_classifier_core #(
    parameter int MOMENTUM_BITS = 32,
    parameter int SPECIES_BITS = 13
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [MOMENTUM_BITS-1:0]              i_p1_x,
    input  logic [MOMENTUM_BITS-1:0]              i_p1_y,
    input  logic [MOMENTUM_BITS-1:0]              i_p1_z,
    input  logic [MOMENTUM_BITS-1:0]              i_p2_x,
    input  logic [MOMENTUM_BITS-1:0]              i_p2_y,
    input  logic [MOMENTUM_BITS-1:0]              i_p2_z,
    input  logic [SPECIES_BITS-1:0]               i_species_1,
    input  logic [SPECIES_BITS-1:0]               i_species_2,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [1:0]                            o_status,
    output logic [1:0]                            o_pair_class,
    output logic [v0im_pkg::OUT_BITS-1:0]         o_pair_energy,
    output logic [v0im_pkg::OUT_BITS-1:0]         o_pair_mass,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [v0im_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [v0im_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import v0im_pkg::*;

    localparam int MR = (MOMENTUM_BITS > 20) ? MOMENTUM_BITS : 21;
    localparam int NW = 2 * MR + 2;
    localparam int SW = NW / 2;
    localparam int PTW = 2 * MOMENTUM_BITS + 2;
    localparam int ET = SW + 1;
    localparam int EW = 2 * ET;
    localparam int OW = OUT_WORD_BITS;

    logic [MASS_BITS-1:0]  r_electron_mass, r_pion_mass, r_proton_mass;
    logic [FLOOR_BITS-1:0] r_min_mass_sq;

    logic                  en;
    logic                  p_valid;
    logic [NW-1:0]         p_n1, p_n2;
    logic [PTW-1:0]        p_pt;
    t_status               p_st;
    t_class                p_cl;

    logic [NW-1:0]         a_rad [0:SW];
    logic [SW+1:0]         a_rem [0:SW];
    logic [SW-1:0]         a_root [0:SW];
    logic [PTW-1:0]        a_pay [0:SW];
    logic [NW-1:0]         b_rad [0:SW];
    logic [SW+1:0]         b_rem [0:SW];
    logic [SW-1:0]         b_root [0:SW];
    logic [3:0]            b_pay [0:SW];
    logic                  r_va [0:SW-1];

    logic                  r1_v, r2_v, r3_v;
    logic [ET-1:0]         r1_etot, r2_etot, r3_etot;
    logic [PTW-1:0]        r1_pt, r2_pt;
    logic [3:0]            r1_sc, r2_sc, r3_sc;
    logic [EW-1:0]         r2_esq, r3_msq;
    logic [EW-1:0]         msq;
    logic                  low;
    t_status               st3;

    logic [EW-1:0]         c_rad [0:ET];
    logic [ET+1:0]         c_rem [0:ET];
    logic [ET-1:0]         c_root [0:ET];
    logic [ET+3:0]         c_pay [0:ET];
    logic                  r_vc [0:ET-1];

    logic [OW-1:0]         d_last;
    t_status               f_st;
    t_class                f_cl;
    logic [ET-1:0]         f_etot;
    logic [OUT_BITS-1:0]   f_energy, f_mass;
    logic                  f_ok;

    logic                  r_out_v, r_skid_v;
    logic [OW-1:0]         r_out, r_skid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_electron_mass <= RST_ELECTRON_MASS;
            r_pion_mass <= RST_PION_MASS;
            r_proton_mass <= RST_PROTON_MASS;
            r_min_mass_sq <= RST_MIN_MASS_SQ;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ELECTRON_MASS: r_electron_mass <= i_cfg_data[MASS_BITS-1:0];
                REG_PION_MASS: r_pion_mass <= i_cfg_data[MASS_BITS-1:0];
                REG_PROTON_MASS: r_proton_mass <= i_cfg_data[MASS_BITS-1:0];
                REG_MIN_MASS_SQ: r_min_mass_sq <= i_cfg_data[FLOOR_BITS-1:0];
                default: r_min_mass_sq <= r_min_mass_sq;
            endcase
        end
    end

    assign en = !r_skid_v;
    assign o_stall = r_skid_v;

    v0im_prep #(
        .MB(MOMENTUM_BITS),
        .SB(SPECIES_BITS)
    ) u_prep (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_en(en),
        .i_valid(i_valid),
        .i_p1_x(i_p1_x),
        .i_p1_y(i_p1_y),
        .i_p1_z(i_p1_z),
        .i_p2_x(i_p2_x),
        .i_p2_y(i_p2_y),
        .i_p2_z(i_p2_z),
        .i_species_1(i_species_1),
        .i_species_2(i_species_2),
        .i_electron_mass(r_electron_mass),
        .i_pion_mass(r_pion_mass),
        .i_proton_mass(r_proton_mass),
        .o_valid(p_valid),
        .o_n1(p_n1),
        .o_n2(p_n2),
        .o_ptot2(p_pt),
        .o_status(p_st),
        .o_class(p_cl)
    );

    assign a_rad[0] = p_n1;
    assign a_rem[0] = '0;
    assign a_root[0] = '0;
    assign a_pay[0] = p_pt;
    assign b_rad[0] = p_n2;
    assign b_rem[0] = '0;
    assign b_root[0] = '0;
    assign b_pay[0] = {p_st, p_cl};

    for (genvar k = 0; k < SW; k++) begin : g_energy
        v0im_sqrt_cell #(.W(NW), .PW(PTW)) u_cell_a (
            .i_clk(i_clk),
            .i_en(en),
            .i_rad(a_rad[k]),
            .i_rem(a_rem[k]),
            .i_root(a_root[k]),
            .i_pay(a_pay[k]),
            .o_rad(a_rad[k+1]),
            .o_rem(a_rem[k+1]),
            .o_root(a_root[k+1]),
            .o_pay(a_pay[k+1])
        );
        v0im_sqrt_cell #(.W(NW), .PW(4)) u_cell_b (
            .i_clk(i_clk),
            .i_en(en),
            .i_rad(b_rad[k]),
            .i_rem(b_rem[k]),
            .i_root(b_root[k]),
            .i_pay(b_pay[k]),
            .o_rad(b_rad[k+1]),
            .o_rem(b_rem[k+1]),
            .o_root(b_root[k+1]),
            .o_pay(b_pay[k+1])
        );
    end

    always_comb begin
        msq = r2_esq - EW'(r2_pt);
        low = (r2_esq < EW'(r2_pt)) || (msq < EW'(r_min_mass_sq));
        st3 = r2_sc[3:2];
        if (st3 == ST_OK && low) begin
            st3 = ST_LOW_MASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_etot <= ET'(a_root[SW]) + ET'(b_root[SW]);
            r1_pt <= a_pay[SW];
            r1_sc <= b_pay[SW];
            r2_esq <= EW'(r1_etot) * EW'(r1_etot);
            r2_pt <= r1_pt;
            r2_sc <= r1_sc;
            r2_etot <= r1_etot;
            r3_msq <= msq;
            r3_sc <= {st3, r2_sc[1:0]};
            r3_etot <= r2_etot;
        end
    end

    assign c_rad[0] = r3_msq;
    assign c_rem[0] = '0;
    assign c_root[0] = '0;
    assign c_pay[0] = {r3_etot, r3_sc};

    for (genvar k = 0; k < ET; k++) begin : g_mass
        v0im_sqrt_cell #(.W(EW), .PW(ET+4)) u_cell_c (
            .i_clk(i_clk),
            .i_en(en),
            .i_rad(c_rad[k]),
            .i_rem(c_rem[k]),
            .i_root(c_root[k]),
            .i_pay(c_pay[k]),
            .o_rad(c_rad[k+1]),
            .o_rem(c_rem[k+1]),
            .o_root(c_root[k+1]),
            .o_pay(c_pay[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SW; k++) begin
                r_va[k] <= 1'b0;
            end
            for (int k = 0; k < ET; k++) begin
                r_vc[k] <= 1'b0;
            end
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r_va[0] <= p_valid;
            for (int k = 1; k < SW; k++) begin
                r_va[k] <= r_va[k-1];
            end
            r1_v <= r_va[SW-1];
            r2_v <= r1_v;
            r3_v <= r2_v;
            r_vc[0] <= r3_v;
            for (int k = 1; k < ET; k++) begin
                r_vc[k] <= r_vc[k-1];
            end
        end
    end

    always_comb begin
        f_etot = c_pay[ET][ET+3:4];
        f_st = c_pay[ET][3:2];
        f_ok = (f_st == ST_OK);
        f_cl = f_ok ? c_pay[ET][1:0] : PHOTON;
        f_energy = (64'(f_etot) > 64'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(f_etot);
        f_mass = (64'(c_root[ET]) > 64'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(c_root[ET]);
        if (!f_ok) begin
            f_energy = '0;
            f_mass = '0;
        end
        d_last = {f_st, f_cl, f_energy, f_mass};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (!i_stall) begin
                    r_skid_v <= 1'b0;
                end
            end else if (r_vc[ET-1]) begin
                if (r_out_v && i_stall) begin
                    r_skid_v <= 1'b1;
                end else begin
                    r_out_v <= 1'b1;
                end
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (r_vc[ET-1]) begin
            if (r_out_v && i_stall) begin
                r_skid <= d_last;
            end else begin
                r_out <= d_last;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_status = r_out[OW-1:OW-2];
    assign o_pair_class = r_out[OW-3:OW-4];
    assign o_pair_energy = r_out[2*OUT_BITS-1:OUT_BITS];
    assign o_pair_mass = r_out[OUT_BITS-1:0];

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a transaction while the output is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_stall) |=> (!r_skid_v && r_out_v))
        else $error("skid did not move into the output register");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_NO_MATCH
                     || o_status == ST_LOW_MASS))
        else $error("status code out of range");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_pair_energy == '0 && o_pair_mass == '0
                                            && o_pair_class == PHOTON))
        else $error("rejected pair carries nonzero results");

    a_mass_le_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |-> (o_pair_mass <= o_pair_energy))
        else $error("mass exceeds energy");

endmodule

// ===== tb/v0im_checker.sv =====
// ----------------------------------------------------------------------------
// v0im_checker
// Watches the pair, result and register channels of the classifier, predicts
// each result from the accepted track pair and the current mass settings, and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module v0im_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               i_stall_in,
    input  logic [31:0]                        i_p1_x,
    input  logic [31:0]                        i_p1_y,
    input  logic [31:0]                        i_p1_z,
    input  logic [31:0]                        i_p2_x,
    input  logic [31:0]                        i_p2_y,
    input  logic [31:0]                        i_p2_z,
    input  logic [12:0]                        i_species_1,
    input  logic [12:0]                        i_species_2,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [1:0]                         i_status,
    input  logic [1:0]                         i_pair_class,
    input  logic [v0im_pkg::OUT_BITS-1:0]      i_pair_energy,
    input  logic [v0im_pkg::OUT_BITS-1:0]      i_pair_mass,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [v0im_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [v0im_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                 o_errors,
    output int                                 o_pending,
    output int                                 o_results,
    output int                                 o_accepted_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import v0im_pkg::*;

    typedef struct packed {
        t_status             status;
        t_class              pair_class;
        logic [OUT_BITS-1:0] energy;
        logic [OUT_BITS-1:0] mass;
    } t_pair_result;

    logic [MASS_BITS-1:0]  electron_mass;
    logic [MASS_BITS-1:0]  pion_mass;
    logic [MASS_BITS-1:0]  proton_mass;
    logic [FLOOR_BITS-1:0] mass_sq_floor;
    t_pair_result          expected_results[$];
    int                    errors;
    int                    results;
    int                    accepted;

    assign o_errors = errors;
    assign o_pending = expected_results.size();
    assign o_results = results;
    assign o_accepted_count = accepted;

    function automatic logic [63:0] floor_root(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = 128'(c) * 128'(c);
            if (n >= sq) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic logic [OUT_BITS-1:0] clip33(logic [63:0] v);
        return (v > 64'(OUT_MAX)) ? OUT_MAX : v[OUT_BITS-1:0];
    endfunction

    function automatic t_pair_result classify_pair(
        logic signed [31:0] px1, logic signed [31:0] py1, logic signed [31:0] pz1,
        logic signed [31:0] px2, logic signed [31:0] py2, logic signed [31:0] pz2,
        logic signed [12:0] sp1, logic signed [12:0] sp2
    );
        t_pair_result r;
        int           a1;
        int           a2;
        logic [63:0]  m1;
        logic [63:0]  m2;
        t_class       cls;
        logic signed [127:0] n1;
        logic signed [127:0] n2;
        logic signed [127:0] ptot2;
        logic signed [127:0] msq;
        logic signed [127:0] sx;
        logic signed [127:0] sy;
        logic signed [127:0] sz;
        logic [63:0]  e1;
        logic [63:0]  e2;
        logic [63:0]  etot;
        r = '{ST_NO_MATCH, PHOTON, '0, '0};
        a1 = (sp1 < 0) ? -int'(sp1) : int'(sp1);
        a2 = (sp2 < 0) ? -int'(sp2) : int'(sp2);
        if (a1 == E_MINUS && a2 == E_MINUS) begin
            m1 = electron_mass;
            m2 = electron_mass;
            cls = PHOTON;
        end else if (a1 == PI_PLUS && a2 == PI_PLUS) begin
            m1 = pion_mass;
            m2 = pion_mass;
            cls = K_SHORT;
        end else if (a1 == PROTON && a2 == PI_PLUS) begin
            m1 = proton_mass;
            m2 = pion_mass;
            cls = (int'(sp1) == PROTON) ? LAMBDA : ANTI_LAMBDA;
        end else if (a1 == PI_PLUS && a2 == PROTON) begin
            m1 = pion_mass;
            m2 = proton_mass;
            cls = (int'(sp2) == PROTON) ? LAMBDA : ANTI_LAMBDA;
        end else begin
            return r;
        end
        n1 = 128'(px1) * 128'(px1) + 128'(py1) * 128'(py1) + 128'(pz1) * 128'(pz1)
            + 128'(m1) * 128'(m1);
        n2 = 128'(px2) * 128'(px2) + 128'(py2) * 128'(py2) + 128'(pz2) * 128'(pz2)
            + 128'(m2) * 128'(m2);
        e1 = floor_root(n1);
        e2 = floor_root(n2);
        etot = e1 + e2;
        sx = 128'(px1) + 128'(px2);
        sy = 128'(py1) + 128'(py2);
        sz = 128'(pz1) + 128'(pz2);
        ptot2 = sx * sx + sy * sy + sz * sz;
        msq = 128'(etot) * 128'(etot) - ptot2;
        if (msq < 0 || msq < 128'(mass_sq_floor)) begin
            r.status = ST_LOW_MASS;
            return r;
        end
        r.status = ST_OK;
        r.pair_class = cls;
        r.energy = clip33(etot);
        r.mass = clip33(floor_root(msq));
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_pair_result want;
        if (!i_rst_n) begin
            electron_mass <= RST_ELECTRON_MASS;
            pion_mass <= RST_PION_MASS;
            proton_mass <= RST_PROTON_MASS;
            mass_sq_floor <= RST_MIN_MASS_SQ;
            expected_results.delete();
            errors = 0;
            results = 0;
            accepted = 0;
        end else begin
            if (i_valid && !i_stall_in) begin
                expected_results.push_back(classify_pair(i_p1_x, i_p1_y, i_p1_z,
                    i_p2_x, i_p2_y, i_p2_z, i_species_1, i_species_2));
                accepted++;
            end
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_pair_class !== want.pair_class)
                        report_mismatch("pair_class", i_pair_class, want.pair_class);
                    if (i_pair_energy !== want.energy)
                        report_mismatch("pair_energy", i_pair_energy, want.energy);
                    if (i_pair_mass !== want.mass)
                        report_mismatch("pair_mass", i_pair_mass, want.mass);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ELECTRON_MASS: electron_mass <= i_cfg_data[MASS_BITS-1:0];
                    REG_PION_MASS: pion_mass <= i_cfg_data[MASS_BITS-1:0];
                    REG_PROTON_MASS: proton_mass <= i_cfg_data[MASS_BITS-1:0];
                    default: mass_sq_floor <= i_cfg_data;
                endcase
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives track pairs and mass settings into the pair invariant mass
// classifier, with random gaps, receiver stalls and one long hold-off, and
// gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import v0im_pkg::*;

    localparam int LATENCY = 75;
    localparam int IDLE_LIMIT = 4000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [31:0]              i_p1_x;
    logic [31:0]              i_p1_y;
    logic [31:0]              i_p1_z;
    logic [31:0]              i_p2_x;
    logic [31:0]              i_p2_y;
    logic [31:0]              i_p2_z;
    logic [12:0]              i_species_1;
    logic [12:0]              i_species_2;
    logic                     o_valid;
    logic                     i_stall;
    logic [1:0]               o_status;
    logic [1:0]               o_pair_class;
    logic [OUT_BITS-1:0]      o_pair_energy;
    logic [OUT_BITS-1:0]      o_pair_mass;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    int                       errors;
    int                       pending;
    int                       results;
    int                       accepted;
    int                       idle_cycles;
    int                       rx_wait;
    bit                       hold_off;

    v0_pair_invariant_mass_classifier_core uut (.*);

    v0im_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_p1_x(i_p1_x), .i_p1_y(i_p1_y), .i_p1_z(i_p1_z),
        .i_p2_x(i_p2_x), .i_p2_y(i_p2_y), .i_p2_z(i_p2_z),
        .i_species_1(i_species_1), .i_species_2(i_species_2),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_status(o_status),
        .i_pair_class(o_pair_class), .i_pair_energy(o_pair_energy),
        .i_pair_mass(o_pair_mass), .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_accepted_count(accepted)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [12:0] pick_species();
        case ($urandom_range(0, 9))
            0: return 13'(E_MINUS);
            1: return -13'sd11;
            2: return 13'(PI_PLUS);
            3: return 13'(PI_NEG);
            4: return 13'(PROTON);
            5: return -13'sd2212;
            6: return 13'h1000;
            7: return 13'($urandom);
            default: return ($urandom_range(0, 1) != 0) ? 13'(PI_PLUS) : 13'(PROTON);
        endcase
    endfunction

    function automatic logic [31:0] pick_momentum();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'($signed($urandom_range(0, 4000)) - 2000);
            default: return 32'($signed($urandom_range(0, 4000000)) - 2000000);
        endcase
    endfunction

    task automatic send_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                             logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                             logic [12:0] s1, logic [12:0] s2);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 1) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        {i_p1_x, i_p1_y, i_p1_z} <= {ax, ay, az};
        {i_p2_x, i_p2_y, i_p2_z} <= {bx, by, bz};
        {i_species_1, i_species_2} <= {s1, s2};
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic send_random_pair();
        send_pair(pick_momentum(), pick_momentum(), pick_momentum(),
                  pick_momentum(), pick_momentum(), pick_momentum(),
                  pick_species(), pick_species());
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_off) begin
            i_stall <= 1'b1;
        end else if (rx_wait != 0) begin
            i_stall <= 1'b1;
            rx_wait <= rx_wait - 1;
        end else begin
            i_stall <= 1'b0;
            if (o_valid) begin
                rx_wait <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 12);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready) || hold_off) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[v0_pair_invariant_mass_classifier_core] ERROR");
            $finish;
        end
    end

    initial begin
        logic [31:0] mx;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        hold_off = 1'b0;
        rx_wait = 0;
        {i_p1_x, i_p1_y, i_p1_z, i_p2_x, i_p2_y, i_p2_z} = '0;
        {i_species_1, i_species_2} = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_ELECTRON_MASS;
        i_cfg_data = '0;
        idle_cycles = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        mx = 32'h8000_0000;
        send_pair(0, 0, 0, 0, 0, 0, 13'(E_MINUS), -13'sd11);
        send_pair(0, 0, 0, 0, 0, 0, 13'(PI_PLUS), 13'(PI_NEG));
        send_pair(100, 0, 0, 0, 200, 0, 13'(PROTON), 13'(PI_NEG));
        send_pair(0, 300, 0, 0, 0, 9, -13'sd2212, 13'(PI_PLUS));
        send_pair(5, 0, 0, 0, 0, 7, 13'(PI_PLUS), 13'(PROTON));
        send_pair(5, 0, 0, 0, 0, 7, 13'(PI_NEG), -13'sd2212);
        send_pair(mx, mx, mx, mx, mx, mx, 13'(PROTON), 13'(PI_PLUS));
        send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 13'(PI_PLUS), 13'(PI_PLUS));
        send_pair(mx, 0, 0, 32'h7fff_ffff, 0, 0, 13'(E_MINUS), 13'(E_MINUS));
        send_pair(1, 2, 3, 4, 5, 6, 13'h1000, 13'(PI_PLUS));
        send_pair(1, 2, 3, 4, 5, 6, 13'(PROTON), 13'(PROTON));
        send_pair(1, 2, 3, 4, 5, 6, 13'h0fff, 13'h1fff);
        send_pair(1000, 0, 0, 1000, 0, 0, 13'(E_MINUS), 13'(E_MINUS));
        drain();

        write_reg(REG_ELECTRON_MASS, 32'd0);
        write_reg(REG_PION_MASS, 32'hfffff);
        write_reg(REG_PROTON_MASS, 32'd0);
        write_reg(REG_MIN_MASS_SQ, 32'd0);
        send_pair(1000, 0, 0, 1000, 0, 0, 13'(E_MINUS), 13'(E_MINUS));
        send_pair(mx, mx, mx, 32'h7fff_ffff, 0, 0, 13'(PROTON), 13'(PI_PLUS));
        send_pair(0, 0, 0, 0, 0, 0, 13'(PI_PLUS), -13'sd2212);
        repeat (300) send_random_pair();
        drain();

        write_reg(REG_MIN_MASS_SQ, 32'hffff_ffff);
        write_reg(REG_ELECTRON_MASS, 32'hfffff);
        write_reg(REG_PROTON_MASS, 32'hfffff);
        write_reg(REG_PION_MASS, 32'd0);
        repeat (300) send_random_pair();
        drain();

        write_reg(REG_ELECTRON_MASS, 32'(RST_ELECTRON_MASS));
        write_reg(REG_PION_MASS, 32'(RST_PION_MASS));
        write_reg(REG_PROTON_MASS, 32'(RST_PROTON_MASS));
        write_reg(REG_MIN_MASS_SQ, 32'($urandom_range(0, 1000000)));
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(negedge i_clk);
                hold_off = 1'b0;
            end
            repeat (150) send_random_pair();
        join
        repeat (380) send_random_pair();
        drain();

        $display("Covered %0d track pairs over four mass settings with %0d results checked.",
                 accepted, results);
        if (errors == 0) begin
            $display("[v0_pair_invariant_mass_classifier_core] OK");
        end else begin
            $display("[v0_pair_invariant_mass_classifier_core] ERROR");
        end
        $finish;
    end

endmodule
